[rtl/ole_pkg.sv]
// Package for the ordered list engine: sizes, command and status codes, cell control.
`default_nettype none
package ole_pkg;

  // Number of cells in the chain
  localparam int LIST_DEPTH = 16;

  // Field widths fixed by the interface
  localparam int VALUE_W    = 32;
  localparam int COMMAND_W  = 2;
  localparam int POSITION_W = 5;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 5;

  // Internal widths derived from the depth
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;

  typedef enum logic [COMMAND_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_HEAD   = 2'd1,
    CMD_POS    = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_BEYOND   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic               ins;      // insert takes effect this cycle
    logic               del;      // delete search/shift takes effect this cycle
    logic [CNT_W-1:0]   ins_pos;  // target index of the insert
    logic [VALUE_W-1:0] value;    // value to insert or to search
  } cell_ctrl_t;

endpackage
`default_nettype wire

[rtl/ole_cell.sv]
// One list cell: holds an entry, compares it, and shifts with its neighbors.
`default_nettype none
module ole_cell
  import ole_pkg::*;
(
  input  wire logic               clk_i,
  input  wire cell_ctrl_t         ctrl_i,
  input  wire logic [IDX_W-1:0]   cell_idx_i,
  input  wire logic [CNT_W-1:0]   count_i,
  input  wire logic [VALUE_W-1:0] left_i,
  input  wire logic [VALUE_W-1:0] right_i,
  input  wire logic               match_i,
  output logic                    match_o,
  output logic [VALUE_W-1:0]      value_o
);

  logic [VALUE_W-1:0] value_q, value_d;
  logic [CNT_W-1:0]   idx_ext;
  logic               occupied;
  logic               hit;

  assign idx_ext  = CNT_W'(cell_idx_i);
  assign occupied = idx_ext < count_i;

  // Pass the first-match flag down the chain
  assign hit     = occupied && (value_q == ctrl_i.value);
  assign match_o = match_i | hit;

  // Shift right above the insert point, load at it, shift left from the match on
  always_comb begin
    value_d = value_q;
    if (ctrl_i.ins) begin
      if (idx_ext > ctrl_i.ins_pos) begin
        value_d = left_i;
      end else if (idx_ext == ctrl_i.ins_pos) begin
        value_d = ctrl_i.value;
      end
    end else if (ctrl_i.del && match_o) begin
      value_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule
`default_nettype wire

[rtl/ordered_list_engine.sv]
// Top level of the ordered list engine: command decode, count and result register.
`default_nettype none
// Bounded ordered list of signed 32-bit values held in a chain of cells.
// Command channel: command_i, value_i and position_i are taken at a rising
// edge where start is high and busy is low. busy stays low, so one
// item can be taken every cycle.
// Commands: append at tail, insert at head, insert at a 0-based position,
// delete the first entry equal to value_i.
// Result channel: done_o is high for exactly one cycle, the cycle after the
// item was taken, with status_o and count_o (entries held afterwards).
// Throughput is 1 item per cycle: all cells compare and
// shift in the same cycle, and the first-match flag ripples through the
// chain in that cycle.
// The receiver cannot stall; each result is shown for one cycle only.
// Reset empties the list and drops any pending result; cell contents are
// not cleared, only the count.
module ordered_list_engine
  import ole_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [COMMAND_W-1:0]         command_i,
  input  wire logic signed [VALUE_W-1:0]    value_i,
  input  wire logic [POSITION_W-1:0]        position_i,
  output logic                              done_o,
  output logic [STATUS_W-1:0]               status_o,
  output logic [COUNT_W-1:0]                count_o
);

  logic               accept;
  cmd_e               cmd;
  cell_ctrl_t         ctrl;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CMP_W-1:0]   pos_ext;
  logic [CMP_W-1:0]   cnt_ext;
  logic               is_insert;
  logic               full;
  logic               found;
  status_e            status_d;
  logic               done_q;
  status_e            status_q;
  logic [COUNT_W-1:0] out_count_q;

  logic [VALUE_W-1:0] vals  [LIST_DEPTH];
  logic               match [LIST_DEPTH+1];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign cmd    = cmd_e'(command_i);

  assign pos_ext = CMP_W'(position_i);
  assign cnt_ext = CMP_W'(count_q);
  assign full    = count_q == CNT_W'(LIST_DEPTH);
  assign found   = match[LIST_DEPTH];

  // Decode the command into cell control and status
  always_comb begin
    is_insert    = 1'b0;
    ctrl.ins     = 1'b0;
    ctrl.del     = 1'b0;
    ctrl.ins_pos = '0;
    ctrl.value   = value_i;
    status_d     = ST_DONE;
    count_d      = count_q;
    unique case (cmd)
      CMD_APPEND: begin
        is_insert    = 1'b1;
        ctrl.ins_pos = count_q;
      end
      CMD_HEAD: begin
        is_insert    = 1'b1;
        ctrl.ins_pos = '0;
      end
      CMD_POS: begin
        is_insert    = 1'b1;
        ctrl.ins_pos = CNT_W'(position_i);
      end
      CMD_DELETE: begin
        is_insert = 1'b0;
      end
      default: begin
        is_insert = 1'b0;
      end
    endcase
    if (is_insert) begin
      priority if (cmd == CMD_POS && pos_ext > cnt_ext) begin
        status_d = ST_BEYOND;
      end else if (full) begin
        status_d = ST_FULL;
      end else begin
        ctrl.ins = accept;
        count_d  = count_q + CNT_W'(1);
      end
    end else begin
      ctrl.del = accept;
      if (found) begin
        count_d = count_q - CNT_W'(1);
      end else begin
        status_d = ST_NOTFOUND;
      end
    end
  end

  // Chain of cells
  assign match[0] = 1'b0;
  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    logic [VALUE_W-1:0] left_val;
    logic [VALUE_W-1:0] right_val;
    if (g == 0) begin : g_first
      assign left_val = ctrl.value;
    end else begin : g_mid_l
      assign left_val = vals[g-1];
    end
    if (g == LIST_DEPTH - 1) begin : g_last
      assign right_val = vals[g];
    end else begin : g_mid_r
      assign right_val = vals[g+1];
    end
    ole_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .cell_idx_i (IDX_W'(g)),
      .count_i    (count_q),
      .left_i     (left_val),
      .right_i    (right_val),
      .match_i    (match[g]),
      .match_o    (match[g+1]),
      .value_o    (vals[g])
    );
  end

  // Advance the count on a taken item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // Hold the result for its one cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      out_count_q <= COUNT_W'(count_d);
    end
  end

  assign done_o   = done_q;
  assign status_o = status_q;
  assign count_o  = out_count_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(LIST_DEPTH))
    else $error("entry count above list depth");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o && (count_o == COUNT_W'(count_q)))
    else $error("result missing or count mismatch after item");

  a_reject_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (status_d != ST_DONE) |=> count_q == $past(count_q))
    else $error("rejected item changed the count");

  a_full_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && full && (cmd != CMD_DELETE) |=> status_o != ST_DONE)
    else $error("insert into full list reported done");
`endif

endmodule
`default_nettype wire

[tb/list_checker.sv]
// Checker for the ordered list engine: tracks the list, predicts each result and compares.
module list_checker
  import ole_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  input  wire logic                      busy,
  input  wire logic [COMMAND_W-1:0]      command_i,
  input  wire logic signed [VALUE_W-1:0] value_i,
  input  wire logic [POSITION_W-1:0]     position_i,
  input  wire logic                      done_o,
  input  wire logic [STATUS_W-1:0]       status_o,
  input  wire logic [COUNT_W-1:0]        count_o,
  output int                             fail_count,
  output int                             pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e             status;
    logic [COUNT_W-1:0]  count;
  } list_result_t;

  // Values held by the list, index 0 is the head
  logic [VALUE_W-1:0] held_values[$];
  // Results still owed by the block, oldest first
  list_result_t       owed_results[$];
  list_result_t       oldest;
  int                 mismatches  = 0;
  int                 outstanding = 0;

  assign fail_count    = mismatches;
  assign pending_count = outstanding;

  // Apply one command to the list copy and return the result it must produce
  function automatic list_result_t apply_command(cmd_e cmd, logic [VALUE_W-1:0] value,
                                                 logic [POSITION_W-1:0] position);
    list_result_t res;
    int           hit = -1;
    int unsigned  target;
    res.status = ST_DONE;
    if (cmd == CMD_DELETE) begin
      foreach (held_values[i]) begin
        if (hit < 0 && held_values[i] == value) hit = i;
      end
      if (hit < 0) res.status = ST_NOTFOUND;
      else held_values.delete(hit);
    end else begin
      case (cmd)
        CMD_APPEND: target = held_values.size();
        CMD_HEAD:   target = 0;
        default:    target = 32'(position);
      endcase
      // Range check wins over the full check
      if (target > held_values.size()) res.status = ST_BEYOND;
      else if (held_values.size() >= LIST_DEPTH) res.status = ST_FULL;
      else held_values.insert(target, value);
    end
    res.count = COUNT_W'(held_values.size());
    return res;
  endfunction

  // Compare the result on the bus first, then record the item taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_values.delete();
      owed_results.delete();
      outstanding = 0;
    end else begin
      if (done_o) begin
        if (owed_results.size() == 0) begin
          $error("result with no item outstanding: status %0d count %0d", status_o, count_o);
          mismatches++;
        end else begin
          oldest = owed_results.pop_front();
          if (status_o !== oldest.status) begin
            $error("status: expected %0d, actual %0d", oldest.status, status_o);
            mismatches++;
          end
          if (count_o !== oldest.count) begin
            $error("count: expected %0d, actual %0d", oldest.count, count_o);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        owed_results.push_back(apply_command(cmd_e'(command_i), value_i, position_i));
      end
      outstanding = owed_results.size();
    end
  end

endmodule

[tb/testbench.sv]
// Top of the ordered list engine testbench: clock, reset, command stimulus and verdict.
module testbench
  import ole_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 50;

  logic                      clk_i      = 1'b0;
  logic                      rst_ni     = 1'b0;
  logic                      start      = 1'b0;
  logic [COMMAND_W-1:0]      command_i  = '0;
  logic signed [VALUE_W-1:0] value_i    = '0;
  logic [POSITION_W-1:0]     position_i = '0;
  logic                      busy;
  logic                      done_o;
  logic [STATUS_W-1:0]       status_o;
  logic [COUNT_W-1:0]        count_o;
  int                        fail_count;
  int                        pending_count;
  int                        cycles   = 0;
  int unsigned               gap_max  = 13;

  // Small pool so that deletes find matches and duplicates occur
  logic [VALUE_W-1:0] common_values[8] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
    32'h7FFF_FFFF, 32'h0000_0055, 32'hAAAA_AAAA, 32'h1234_5678
  };

  ordered_list_engine u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .command_i  (command_i),
    .value_i    (value_i),
    .position_i (position_i),
    .done_o     (done_o),
    .status_o   (status_o),
    .count_o    (count_o)
  );

  list_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .value_i       (value_i),
    .position_i    (position_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .count_o       (count_o),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Present one item after a random gap and hold it until it is taken
  task automatic issue_item(cmd_e cmd, logic [VALUE_W-1:0] value,
                            logic [POSITION_W-1:0] position);
    int unsigned gap;
    logic        taken;
    gap = $urandom_range(0, gap_max);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    command_i  <= cmd;
    value_i    <= value;
    position_i <= position;
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Stop sending and hold until every result has come back
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Draw one random command, biased toward inserts by insert_pct
  task automatic issue_random(int unsigned insert_pct);
    cmd_e                  cmd;
    logic [VALUE_W-1:0]    value;
    logic [POSITION_W-1:0] position;
    if ($urandom_range(0, 99) < insert_pct) cmd = cmd_e'($urandom_range(0, 2));
    else cmd = CMD_DELETE;
    if ($urandom_range(0, 3) == 0) value = $urandom;
    else value = common_values[$urandom_range(0, 7)];
    if ($urandom_range(0, 7) == 0) position = POSITION_W'($urandom_range(0, 31));
    else position = POSITION_W'($urandom_range(0, LIST_DEPTH + 1));
    issue_item(cmd, value, position);
  endtask

  initial begin
    int unsigned insert_pct;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty list cases, each insert kind, duplicates, then fill up
    issue_item(CMD_DELETE, 32'h0000_0005, 5'd0);
    issue_item(CMD_POS,    32'h0000_0009, 5'd1);
    issue_item(CMD_POS,    32'h8000_0000, 5'd0);
    issue_item(CMD_APPEND, 32'h7FFF_FFFF, 5'd31);
    issue_item(CMD_HEAD,   32'hFFFF_FFFF, 5'd17);
    issue_item(CMD_POS,    32'h0000_0000, 5'd3);
    issue_item(CMD_POS,    32'h7FFF_FFFF, 5'd2);
    issue_item(CMD_DELETE, 32'h7FFF_FFFF, 5'd0);
    issue_item(CMD_DELETE, 32'h1234_5678, 5'd0);
    for (int i = 0; i < LIST_DEPTH - 4; i++) begin
      issue_item(CMD_APPEND, common_values[i % 8], 5'(i));
    end
    // Full list: range check first, then each insert kind dropped
    issue_item(CMD_POS,    32'h0000_0011, 5'd31);
    issue_item(CMD_POS,    32'h0000_0011, 5'd16);
    issue_item(CMD_HEAD,   32'h0000_0011, 5'd0);
    issue_item(CMD_APPEND, 32'h0000_0011, 5'd0);
    issue_item(CMD_DELETE, 32'h8000_0000, 5'd0);
    drain_results();

    // Random phases: alternate insert-heavy and delete-heavy, with and without gaps
    for (int phase = 0; phase < PHASES; phase++) begin
      gap_max    = (phase % 3 == 1) ? 0 : 13;
      insert_pct = (phase % 2 == 0) ? 80 : 30;
      if (phase == PHASES - 1) insert_pct = 55;
      for (int n = 0; n < PHASE_ITEMS; n++) issue_random(insert_pct);
      if (phase % 2 == 1) drain_results();
    end

    // Finish: drain, let the pipeline settle, report
    drain_results();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      if (pending_count != 0) $error("%0d results never arrived", pending_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/ole_pkg.sv
rtl/ole_cell.sv
rtl/ordered_list_engine.sv
tb/list_checker.sv
tb/testbench.sv
